// ----- design/alle_pkg.sv -----
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types, codes and sizes for the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int LINK_W       = 7;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_REMOVE = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 3'd0,
    ST_ELEMENT      = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_FULL         = 3'd3,
    ST_BAD_POSITION = 3'd4,
    ST_EMPTY        = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_INS_LINK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [LINK_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
  } out_item_t;

endpackage

// ----- design/alle_chan_if.sv -----
// ----------------------------------------------------------------------------
// alle_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface alle_chan_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- design/alle_out_reg.sv -----
// ----------------------------------------------------------------------------
// alle_out_reg
// Output register for result transactions; frees when the sink takes it.
// ----------------------------------------------------------------------------
module alle_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  alle_pkg::out_item_t load_item,
  output logic               free,
  alle_chan_if.source        out_ch
);
  import alle_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign free      = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.payload = item_r;

endmodule

// ----- design/array_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Doubly linked list of signed values in slot memories, slot 0 the sentinel.
// Insert at position k: walks k links, writes the new slot, then links it (S_INS_LINK).
// Remove: walks from the head to the first matching value; no match ends at the list tail.
// Dump: head first, then one element per cycle while output free (link read loop).
// One command in flight; a new transaction is taken once the previous finishes.
// Reset clears the sentinel links and counters at once; no clearing pass.
// ----------------------------------------------------------------------------
module array_linked_list_engine #(
  parameter int CAPACITY = alle_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  alle_chan_if.sink   in_ch,
  alle_chan_if.source out_ch
);
  import alle_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int DEPTH = CAPACITY + 1;

  logic signed [VALUE_W-1:0] val_mem [DEPTH];
  logic [IDX_W-1:0]          nx_mem  [DEPTH];
  logic [IDX_W-1:0]          pv_mem  [DEPTH];

  state_t                    state_r, state_nxt;
  logic [CMD_W-1:0]          cmd_r, cmd_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]          cur_r, cur_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt;
  logic [IDX_W-1:0]          aux_r, aux_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [IDX_W-1:0]          tail_r, tail_nxt;
  logic [IDX_W-1:0]          used_r, used_nxt;
  logic [IDX_W-1:0]          len_r, len_nxt;
  status_t                   status_r, status_nxt;

  logic signed [VALUE_W-1:0] val_q;
  logic [IDX_W-1:0]          nx_q;
  logic [IDX_W-1:0]          pv_q;

  logic             val_we;
  logic             nx_we;
  logic [IDX_W-1:0] nx_wa;
  logic [IDX_W-1:0] nx_wd;
  logic             pv_we;
  logic [IDX_W-1:0] pv_wa;
  logic [IDX_W-1:0] pv_wd;

  logic      load;
  out_item_t load_item;
  logic      out_free;

  logic              in_fire;
  logic              dec_full;
  logic              dec_bad;
  logic [LINK_W:0]   len_plus1;
  logic              head_empty;
  logic [IDX_W-1:0]  eff_next;
  logic [IDX_W-1:0]  eff_prev;
  logic [IDX_W-1:0]  s_slot;
  logic              val_hit;
  logic              dump_last;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign len_plus1  = (LINK_W + 1)'(len_r) + (LINK_W + 1)'(1);
  assign dec_full   = (used_r >= IDX_W'(CAPACITY));
  assign dec_bad    = ({1'b0, in_ch.payload.position} > len_plus1);
  assign head_empty = (head_r == '0);

  assign eff_next  = (cur_r == '0) ? head_r : nx_q;
  assign eff_prev  = (cur_r == '0) ? tail_r : pv_q;
  assign s_slot    = used_r + IDX_W'(1);
  assign val_hit   = (cur_r != '0) && (val_q == value_r);
  assign dump_last = (nx_q == '0) || (cnt_r == IDX_W'(CAPACITY - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.payload.cmd)
            CMD_REMOVE: state_nxt = S_WALK;
            CMD_INSERT: state_nxt = (dec_full || dec_bad) ? S_RESP : S_WALK;
            CMD_DUMP:   state_nxt = head_empty ? S_RESP : S_WALK;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        case (cmd_r)
          CMD_REMOVE: begin
            if (cur_r == '0) begin
              state_nxt = head_empty ? S_RESP : S_WALK;
            end else if (val_hit || (nx_q == '0)) begin
              state_nxt = S_RESP;
            end
          end
          CMD_INSERT: begin
            if (cnt_r == '0) begin
              state_nxt = S_INS_LINK;
            end
          end
          CMD_DUMP: begin
            if ((cur_r != '0) && out_free && dump_last) begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_LINK: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt    = cmd_r;
    value_nxt  = value_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    aux_nxt    = aux_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    val_we     = 1'b0;
    nx_we      = 1'b0;
    nx_wa      = '0;
    nx_wd      = '0;
    pv_we      = 1'b0;
    pv_wa      = '0;
    pv_wd      = '0;
    load       = 1'b0;
    load_item  = '{status: status_r, data: '0, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_ch.payload.cmd;
          value_nxt = in_ch.payload.value;
          cur_nxt   = '0;
          cnt_nxt   = '0;
          case (in_ch.payload.cmd)
            CMD_INSERT: begin
              status_nxt = dec_full ? ST_FULL : ST_BAD_POSITION;
              cnt_nxt    = in_ch.payload.position[IDX_W-1:0];
            end
            CMD_DUMP: status_nxt = ST_EMPTY;
            default:  status_nxt = ST_NOT_FOUND;
          endcase
        end
      end
      S_WALK: begin
        case (cmd_r)
          CMD_REMOVE: begin
            if (cur_r == '0) begin
              cur_nxt    = head_r;
              status_nxt = ST_NOT_FOUND;
            end else if (val_hit) begin
              if (pv_q == '0) begin
                head_nxt = nx_q;
              end else begin
                nx_we = 1'b1;
                nx_wa = pv_q;
                nx_wd = nx_q;
              end
              if (nx_q == '0) begin
                tail_nxt = pv_q;
              end else begin
                pv_we = 1'b1;
                pv_wa = nx_q;
                pv_wd = pv_q;
              end
              if (len_r != '0) begin
                len_nxt = len_r - IDX_W'(1);
              end
              status_nxt = ST_DONE;
            end else begin
              cur_nxt = nx_q;
            end
          end
          CMD_INSERT: begin
            if (cnt_r == '0) begin
              val_we  = 1'b1;
              nx_we   = 1'b1;
              nx_wa   = s_slot;
              nx_wd   = cur_r;
              pv_we   = 1'b1;
              pv_wa   = s_slot;
              pv_wd   = eff_prev;
              aux_nxt = eff_prev;
            end else begin
              cur_nxt = eff_next;
              cnt_nxt = cnt_r - IDX_W'(1);
            end
          end
          CMD_DUMP: begin
            if (cur_r == '0) begin
              cur_nxt = head_r;
            end else if (out_free) begin
              load      = 1'b1;
              load_item = '{status: ST_ELEMENT, data: val_q, last: dump_last};
              cur_nxt   = nx_q;
              cnt_nxt   = cnt_r + IDX_W'(1);
            end
          end
          default: ;
        endcase
      end
      S_INS_LINK: begin
        if (aux_r == '0) begin
          head_nxt = s_slot;
        end else begin
          nx_we = 1'b1;
          nx_wa = aux_r;
          nx_wd = s_slot;
        end
        if (cur_r == '0) begin
          tail_nxt = s_slot;
        end else begin
          pv_we = 1'b1;
          pv_wa = cur_r;
          pv_wd = s_slot;
        end
        used_nxt   = s_slot;
        len_nxt    = len_r + IDX_W'(1);
        status_nxt = ST_DONE;
      end
      S_RESP: begin
        load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      used_r  <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      used_r  <= used_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    value_r  <= value_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    aux_r    <= aux_nxt;
    status_r <= status_nxt;
  end

  // Writes land before any later read of the same slot: each command ends
  // its writes before the next transaction is taken.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[s_slot] <= value_r;
    end
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    val_q <= val_mem[cur_nxt];
    nx_q  <= nx_mem[cur_nxt];
    pv_q  <= pv_mem[cur_nxt];
  end

  alle_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_item (load_item),
    .free      (out_free),
    .out_ch    (out_ch)
  );

  a_len_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= used_r)
    else $error("list length exceeds slots handed out");

  a_empty_links: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == '0) == (tail_r == '0))
    else $error("sentinel head and tail disagree on emptiness");

  a_len_head: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) == (head_r == '0))
    else $error("list length disagrees with sentinel head");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.payload.cmd == CMD_INSERT) && dec_full) |=> $stable(used_r))
    else $error("slot counter moved on a full insert");

endmodule
